// ===== rtl/bclm_pkg.sv =====
// shared types and constants for the block cache core
package bclm_pkg;

  localparam int KeyW    = 31;
  localparam int WordW   = 64;
  localparam int IdxW    = 6;
  localparam int CapW    = 5;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgPolicy   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCapacity = 1'b1;

  typedef enum logic [2:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_INSERTED = 3'd2,
    ST_EVICTED  = 3'd3,
    ST_STAGED   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_HIT_RD,
    S_HIT_OUT,
    S_COPY,
    S_COPY_END,
    S_UPDATE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    decide;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    fill_rd;
    logic    store_rd;
    logic    update;
    logic    resp_load;
    status_e resp_status;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic last_word;
    logic hit;
    logic evict;
    logic cnt_last;
  } sts_t;

endpackage

// ===== rtl/bclm_ctrl.sv =====
// sequencing state machine for lookups, staging and commits
module bclm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  bclm_pkg::sts_t sts_i,
  output bclm_pkg::cmd_t cmd_o
);
  import bclm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.action) begin
          state_d = sts_i.hit ? S_HIT_RD : S_RESP;
        end else begin
          state_d = sts_i.last_word ? S_COPY : S_RESP;
        end
      end
      S_HIT_RD: state_d = S_HIT_OUT;
      S_HIT_OUT: begin
        if (!out_stall_i) state_d = sts_i.cnt_last ? S_UPDATE : S_HIT_RD;
      end
      S_COPY: begin
        if (sts_i.cnt_last) state_d = S_COPY_END;
      end
      S_COPY_END: state_d = S_UPDATE;
      S_UPDATE: state_d = sts_i.action ? S_RESP : S_IDLE;
      S_RESP: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.resp_status = ST_MISS;
    case (state_q)
      S_IDLE: cmd_o.capture = in_valid_i;
      S_DECIDE: begin
        cmd_o.decide  = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        if (!sts_i.action && !sts_i.hit) begin
          cmd_o.resp_load   = 1'b1;
          cmd_o.resp_status = ST_MISS;
        end else if (sts_i.action && !sts_i.last_word) begin
          cmd_o.resp_load   = 1'b1;
          cmd_o.resp_status = ST_STAGED;
        end
      end
      S_HIT_RD: begin
        cmd_o.store_rd    = 1'b1;
        cmd_o.resp_load   = 1'b1;
        cmd_o.resp_status = ST_HIT;
      end
      S_HIT_OUT: cmd_o.cnt_inc = !out_stall_i && !sts_i.cnt_last;
      S_COPY: begin
        cmd_o.fill_rd = 1'b1;
        cmd_o.cnt_inc = !sts_i.cnt_last;
      end
      S_UPDATE: begin
        cmd_o.update      = 1'b1;
        cmd_o.resp_load   = sts_i.action;
        cmd_o.resp_status = sts_i.evict ? ST_EVICTED : ST_INSERTED;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_HIT_OUT) || (state_q == S_RESP);

endmodule

// ===== rtl/bclm_dp.sv =====
// tags, recency ranks, fill buffer, block store and result registers
module bclm_dp #(
  parameter int ENTRIES         = 16,
  parameter int WORDS_PER_BLOCK = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bclm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bclm_pkg::CapW-1:0]         cfg_data_i,
  input  logic                              action_i,
  input  logic [bclm_pkg::KeyW-1:0]         block_key_i,
  input  logic [bclm_pkg::IdxW-1:0]         word_index_i,
  input  logic [bclm_pkg::WordW-1:0]        block_word_i,
  input  logic                              last_word_i,
  input  bclm_pkg::cmd_t                    cmd_i,
  output bclm_pkg::sts_t                    sts_o,
  output logic [2:0]                        status_o,
  output logic [bclm_pkg::IdxW-1:0]         word_index_out_o,
  output logic [bclm_pkg::WordW-1:0]        word_out_o,
  output logic [bclm_pkg::KeyW-1:0]         evicted_key_o,
  output logic                              last_o
);
  import bclm_pkg::*;

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > CapW) ? OW : CapW;
  localparam int WI = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int AW = (ENTRIES * WORDS_PER_BLOCK > 1) ?
                      $clog2(ENTRIES * WORDS_PER_BLOCK) : 1;
  localparam int SD = ENTRIES * WORDS_PER_BLOCK;

  logic             policy_q;
  logic [CapW-1:0]  cap_q;
  logic             action_q, last_word_q;
  logic [KeyW-1:0]  key_q;
  logic [IdxW-1:0]  widx_q;
  logic [WordW-1:0] word_q;

  logic [KeyW-1:0]  keys_q  [ENTRIES];
  logic [RW-1:0]    rank_q  [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [OW-1:0]    occ_q;

  logic [RW-1:0]    slot_q, rsel_q;
  logic             hit_q, evict_q;
  logic [KeyW-1:0]  ekey_q;
  logic [WI-1:0]    cnt_q;

  logic [WordW-1:0] fill_mem [WORDS_PER_BLOCK];
  logic [WordW-1:0] fill_rdata_q;
  logic [WordW-1:0] store_mem [SD];
  logic [WordW-1:0] store_rdata_q;
  logic             wr_pend_q;
  logic [AW-1:0]    wr_addr_q;
  logic [AW-1:0]    store_addr;

  status_e          out_status_q;
  logic [IdxW-1:0]  out_idx_q;
  logic [KeyW-1:0]  out_ekey_q;
  logic             out_last_q;

  logic [ENTRIES-1:0] match;
  logic [RW-1:0]    hit_slot, free_slot, victim, target;
  logic             any_hit, victim_found, free_found, evict;
  logic [CW-1:0]    cap_ext, cap_eff;
  logic             cnt_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
      cap_q    <= CapW'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPolicy:   policy_q <= cfg_data_i[0];
        CfgCapacity: cap_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q    <= action_i;
      key_q       <= block_key_i;
      widx_q      <= word_index_i;
      word_q      <= block_word_i;
      last_word_q <= last_word_i;
    end
  end

  always_comb begin
    any_hit      = 1'b0;
    hit_slot     = '0;
    free_found   = 1'b0;
    free_slot    = '0;
    victim_found = 1'b0;
    victim       = '0;
    target       = policy_q ? '0 : RW'(occ_q - OW'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (keys_q[i] == key_q);
      if (match[i] && !any_hit) begin
        any_hit  = 1'b1;
        hit_slot = RW'(i);
      end
      if (!valid_q[i] && !free_found) begin
        free_found = 1'b1;
        free_slot  = RW'(i);
      end
      if (valid_q[i] && rank_q[i] == target && !victim_found) begin
        victim_found = 1'b1;
        victim       = RW'(i);
      end
    end
    cap_ext = CW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    evict = (CW'(occ_q) >= cap_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      evict_q <= 1'b0;
    end else if (cmd_i.decide) begin
      hit_q   <= any_hit;
      evict_q <= !any_hit && evict;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      ekey_q <= keys_q[victim];
      if (any_hit) begin
        slot_q <= hit_slot;
        rsel_q <= rank_q[hit_slot];
      end else if (evict) begin
        slot_q <= victim;
        rsel_q <= rank_q[victim];
      end else begin
        slot_q <= free_slot;
        rsel_q <= rank_q[free_slot];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else if (cmd_i.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (RW'(i) == slot_q) begin
          rank_q[i] <= '0;
        end else if (valid_q[i]) begin
          if (hit_q) begin
            if (rank_q[i] < rsel_q) rank_q[i] <= rank_q[i] + RW'(1);
          end else if (evict_q) begin
            if (rank_q[i] <= rsel_q) rank_q[i] <= rank_q[i] + RW'(1);
          end else begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end
        end
      end
      valid_q[slot_q] <= 1'b1;
      if (!hit_q && !evict_q) occ_q <= occ_q + OW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && !hit_q) keys_q[slot_q] <= key_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + WI'(1);
    end
  end
  assign cnt_last = (cnt_q == WI'(WORDS_PER_BLOCK - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && action_q && (int'(widx_q) < WORDS_PER_BLOCK)) begin
      fill_mem[widx_q[WI-1:0]] <= word_q;
    end
    if (cmd_i.fill_rd) fill_rdata_q <= fill_mem[cnt_q];
  end

  assign store_addr = AW'(int'(slot_q) * WORDS_PER_BLOCK + int'(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.fill_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_rd) wr_addr_q <= store_addr;
    if (wr_pend_q) store_mem[wr_addr_q] <= fill_rdata_q;
    if (cmd_i.store_rd) store_rdata_q <= store_mem[store_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_status_q <= ST_MISS;
      out_idx_q    <= '0;
      out_ekey_q   <= '0;
      out_last_q   <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_status_q <= cmd_i.resp_status;
      out_idx_q    <= (cmd_i.resp_status == ST_HIT) ? IdxW'(cnt_q) : '0;
      out_ekey_q   <= (cmd_i.resp_status == ST_EVICTED) ? ekey_q : '0;
      out_last_q   <= (cmd_i.resp_status == ST_HIT) ? cnt_last : 1'b1;
    end
  end

  assign status_o         = out_status_q;
  assign word_index_out_o = out_idx_q;
  assign word_out_o       = (out_status_q == ST_HIT) ? store_rdata_q : '0;
  assign evicted_key_o    = out_ekey_q;
  assign last_o           = out_last_q;

  assign sts_o.action    = action_q;
  assign sts_o.last_word = last_word_q;
  assign sts_o.hit       = any_hit;
  assign sts_o.evict     = evict_q;
  assign sts_o.cnt_last  = cnt_last;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= ENTRIES) else $error("occupancy above entry count");
  a_no_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match)) else $error("key cached in two entries");
  a_occ_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q)) else $error("occupancy out of step");

endmodule

// ===== rtl/block_cache_lru_mru_core.sv =====
// fully associative block cache with lru or mru replacement, top level
// miss or staged word: the result is loaded in the decide state and presented in the response state
// hit: each streamed word is read from the block store, then presented until the output takes it
// commit: one fill buffer word copied per cycle, then tags and ranks update and the result is sent
// one item at a time; input stalls until the core is idle again after its last result word is taken
// reset clears valid bits, ranks and occupancy, sets config to lru and capacity 16; no clearing pass
module block_cache_lru_mru_core #(
  parameter int ENTRIES         = 16,
  parameter int WORDS_PER_BLOCK = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bclm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bclm_pkg::CapW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [bclm_pkg::KeyW-1:0]    block_key_i,
  input  logic [bclm_pkg::IdxW-1:0]    word_index_i,
  input  logic [bclm_pkg::WordW-1:0]   block_word_i,
  input  logic                         last_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [bclm_pkg::IdxW-1:0]    word_index_out_o,
  output logic [bclm_pkg::WordW-1:0]   word_out_o,
  output logic [bclm_pkg::KeyW-1:0]    evicted_key_o,
  output logic                         last_o
);
  import bclm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bclm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bclm_dp #(
    .ENTRIES         (ENTRIES),
    .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .block_key_i      (block_key_i),
    .word_index_i     (word_index_i),
    .block_word_i     (block_word_i),
    .last_word_i      (last_word_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .word_index_out_o (word_index_out_o),
    .word_out_o       (word_out_o),
    .evicted_key_o    (evicted_key_o),
    .last_o           (last_o)
  );

endmodule
